// ----- rtl/vrdc_pkg.sv -----
// Shared types, codes and the microcode program of the vault request splitter.
`timescale 1ns / 1ps

package vrdc_pkg;

	// Request kinds carried in the input word's tuser
	localparam logic [2:0] FN_WR   = 3'd0;
	localparam logic [2:0] FN_PWR  = 3'd1;
	localparam logic [2:0] FN_RD   = 3'd2;
	localparam logic [2:0] FN_ATM  = 3'd3;
	localparam logic [2:0] FN_PATM = 3'd4;

	// Access granule: one read or write command moves 32 bytes
	localparam int GRAIN_SHIFT = 5;
	localparam logic [9:0] GRAIN_ROUND = 10'd31;

	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 64;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CMD_ACT = 3'd0,
		CMD_RD  = 3'd1,
		CMD_RDP = 3'd2,
		CMD_WR  = 3'd3,
		CMD_WRP = 3'd4
	} cmd_kind_t;

	typedef enum logic [1:0] {
		EMIT_NONE   = 2'd0,
		EMIT_STATUS = 2'd1,
		EMIT_ACT    = 2'd2,
		EMIT_ACC    = 2'd3
	} emit_t;

	typedef enum logic [2:0] {
		COND_ALWAYS    = 3'd0,
		COND_NO_INPUT  = 3'd1,
		COND_REJECT    = 3'd2,
		COND_NO_ACCESS = 3'd3,
		COND_MORE      = 3'd4
	} cond_t;

	typedef logic [2:0] step_t;

	localparam step_t STEP_IDLE   = 3'd0;
	localparam step_t STEP_CHECK  = 3'd1;
	localparam step_t STEP_ACT    = 3'd2;
	localparam step_t STEP_STATUS = 3'd3;
	localparam step_t STEP_ACC    = 3'd4;

	// One control word: take true branch to tgt, else go to nxt
	typedef struct packed {
		logic  accept;
		emit_t emit;
		cond_t cond;
		step_t tgt;
		step_t nxt;
	} ctl_t;

	// Datapath conditions seen by the sequencer
	typedef struct packed {
		logic in_valid;
		logic reject;
		logic no_access;
		logic more;
		logic out_free;
	} flags_t;

	function automatic ctl_t ucode(input step_t s);
		ctl_t w;
		w = '{accept: 1'b0, emit: EMIT_NONE, cond: COND_ALWAYS,
			tgt: STEP_IDLE, nxt: STEP_IDLE};
		case (s)
			STEP_IDLE:   w = '{accept: 1'b1, emit: EMIT_NONE, cond: COND_NO_INPUT,
				tgt: STEP_IDLE, nxt: STEP_CHECK};
			STEP_CHECK:  w = '{accept: 1'b0, emit: EMIT_NONE, cond: COND_REJECT,
				tgt: STEP_STATUS, nxt: STEP_ACT};
			STEP_ACT:    w = '{accept: 1'b0, emit: EMIT_ACT, cond: COND_NO_ACCESS,
				tgt: STEP_IDLE, nxt: STEP_ACC};
			STEP_STATUS: w = '{accept: 1'b0, emit: EMIT_STATUS, cond: COND_ALWAYS,
				tgt: STEP_IDLE, nxt: STEP_IDLE};
			STEP_ACC:    w = '{accept: 1'b0, emit: EMIT_ACC, cond: COND_MORE,
				tgt: STEP_ACC, nxt: STEP_IDLE};
			default:     w = '{accept: 1'b0, emit: EMIT_NONE, cond: COND_ALWAYS,
				tgt: STEP_IDLE, nxt: STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/vrdc_useq.sv -----
// Microcode sequencer: step counter, control store lookup and two-way branch.
`timescale 1ns / 1ps

module vrdc_useq (
	input  logic             clk,
	input  logic             arst_n,
	input  vrdc_pkg::flags_t flags,
	output vrdc_pkg::ctl_t   ctl,
	output logic             go,
	output vrdc_pkg::step_t  step
);
	import vrdc_pkg::*;

	step_t step_q;
	step_t step_d;
	logic  cond_hit;

	always_comb begin
		ctl = ucode(step_q);
	end

	// hold the step while its word is waiting for the output register
	assign go = (ctl.emit == EMIT_NONE) || flags.out_free;

	always_comb begin
		case (ctl.cond)
			COND_ALWAYS:    cond_hit = 1'b1;
			COND_NO_INPUT:  cond_hit = !flags.in_valid;
			COND_REJECT:    cond_hit = flags.reject;
			COND_NO_ACCESS: cond_hit = flags.no_access;
			COND_MORE:      cond_hit = flags.more;
			default:        cond_hit = 1'b1;
		endcase
	end

	always_comb begin
		step_d = step_q;
		if (go) begin
			step_d = cond_hit ? ctl.tgt : ctl.nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	assign step = step_q;

endmodule

// ----- rtl/vrdc_dpath.sv -----
// Datapath: request capture, address map, access counter and output register.
`timescale 1ns / 1ps

module vrdc_dpath #(
	parameter int MAX_BLOCK_BYTES   = 128,
	parameter int VAULT_COUNT       = 32,
	parameter int BANK_COUNT        = 16,
	parameter int COLUMN_COUNT      = 1024,
	parameter int ROW_COUNT         = 32768,
	parameter int MAX_REQUEST_BYTES = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  vrdc_pkg::ctl_t                      ctl,
	input  logic                                go,
	input  logic                                s_tvalid,
	input  logic [vrdc_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic [2:0]                          s_tuser,
	input  logic                                m_tready,
	input  logic                                cfg_we,
	input  logic                                cfg_wdata,
	output vrdc_pkg::flags_t                    flags,
	output logic                                m_tvalid,
	output logic [vrdc_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic [4:0]                          m_tuser,
	output logic                                m_tlast
);
	import vrdc_pkg::*;

	localparam int LG_MB = $clog2(MAX_BLOCK_BYTES);
	localparam int LG_VC = $clog2(VAULT_COUNT);
	localparam int LG_BC = $clog2(BANK_COUNT);
	localparam int LG_CC = $clog2(COLUMN_COUNT);
	localparam int SH_BANK = LG_MB + LG_VC;
	localparam int SH_COL  = SH_BANK + LG_BC;
	localparam int SH_ROW  = SH_COL + ((LG_CC > LG_MB) ? (LG_CC - LG_MB) : 0);
	localparam logic [33:0] BANK_MASK = 34'(BANK_COUNT - 1);
	localparam logic [33:0] COL_MASK  = 34'((COLUMN_COUNT - 1) >> LG_MB);
	localparam logic [33:0] ROW_MASK  = 34'(ROW_COUNT - 1);
	localparam logic [8:0]  SIZE_MAX  = 9'(MAX_REQUEST_BYTES);

	// input word fields
	logic [5:0]  in_op;
	logic [33:0] in_addr;
	logic [8:0]  in_size;
	logic [10:0] in_tag;
	logic [6:0]  in_free;

	assign in_op   = s_tdata[5:0];
	assign in_addr = s_tdata[39:6];
	assign in_size = s_tdata[48:40];
	assign in_tag  = s_tdata[59:49];
	assign in_free = s_tdata[66:60];

	logic [8:0] sat_size;
	logic [3:0] n_acc;
	logic [3:0] bank_d;
	logic [9:0] col_d;
	logic [14:0] row_d;
	logic [33:0] col_blk;

	always_comb begin
		sat_size = (in_size > SIZE_MAX) ? SIZE_MAX : in_size;
		n_acc    = 4'((10'(sat_size) + GRAIN_ROUND) >> GRAIN_SHIFT);
		bank_d   = 4'((in_addr >> SH_BANK) & BANK_MASK);
		col_blk  = (in_addr >> SH_COL) & COL_MASK;
		col_d    = 10'(col_blk << LG_MB);
		row_d    = 15'((in_addr >> SH_ROW) & ROW_MASK);
	end

	// captured request
	logic [5:0]  op_q;
	logic [10:0] tag_q;
	logic [3:0]  bank_q;
	logic [9:0]  col_q;
	logic [14:0] row_q;
	logic [8:0]  size_q;
	logic [3:0]  n_q;
	logic [3:0]  idx_q;
	logic        invalid_q;
	logic        full_q;
	logic        write_q;
	logic        posted_q;
	logic        atomic_q;
	logic        keep_rows_q;

	logic load;
	logic fire;
	logic last;

	assign load = ctl.accept && s_tvalid;
	assign fire = go && (ctl.emit != EMIT_NONE);
	assign last = ((idx_q + 4'd1) == n_q);

	always_ff @(posedge clk) begin
		if (load) begin
			op_q      <= in_op;
			tag_q     <= in_tag;
			bank_q    <= bank_d;
			col_q     <= col_d;
			row_q     <= row_d;
			size_q    <= sat_size;
			n_q       <= n_acc;
			invalid_q <= (s_tuser > FN_PATM);
			full_q    <= (in_free < (7'(n_acc) + 7'd1));
			write_q   <= (s_tuser == FN_WR) || (s_tuser == FN_PWR);
			posted_q  <= (s_tuser == FN_PWR) || (s_tuser == FN_PATM);
			atomic_q  <= (s_tuser == FN_ATM) || (s_tuser == FN_PATM);
		end
		if (load) begin
			idx_q <= '0;
		end else if (fire && (ctl.emit == EMIT_ACC)) begin
			idx_q <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_rows_q <= 1'b1;
		end else if (cfg_we) begin
			keep_rows_q <= cfg_wdata;
		end
	end

	// result word assembled from the current control word
	status_t   st_d;
	cmd_kind_t kind_d;
	logic [8:0] osize_d;
	logic posted_d;
	logic atomic_d;
	logic lacc_d;
	logic lrun_d;
	logic pre;

	always_comb begin
		pre      = last && !atomic_q && !keep_rows_q;
		st_d     = ST_OK;
		kind_d   = CMD_ACT;
		osize_d  = '0;
		posted_d = 1'b0;
		atomic_d = 1'b0;
		lacc_d   = 1'b0;
		lrun_d   = 1'b1;
		case (ctl.emit)
			EMIT_STATUS: begin
				st_d = invalid_q ? ST_BAD : ST_FULL;
			end
			EMIT_ACT: begin
				atomic_d = atomic_q;
				lacc_d   = 1'b1;
				lrun_d   = (n_q == 4'd0);
			end
			EMIT_ACC: begin
				if (write_q) begin
					kind_d = pre ? CMD_WRP : CMD_WR;
				end else begin
					kind_d = pre ? CMD_RDP : CMD_RD;
				end
				osize_d  = size_q;
				posted_d = posted_q;
				atomic_d = atomic_q;
				lacc_d   = last;
				lrun_d   = last;
			end
			default: begin
				st_d = ST_OK;
			end
		endcase
	end

	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [4:0]            m_tuser_q;
	logic                  m_tlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_tdata_q <= {6'd0, op_q, lacc_d, atomic_d, posted_d, osize_d,
				row_q, col_q, bank_q, tag_q};
			m_tuser_q <= {kind_d, st_d};
			m_tlast_q <= lrun_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	assign flags = '{in_valid: s_tvalid, reject: invalid_q || full_q,
		no_access: (n_q == 4'd0), more: !last,
		out_free: !m_tvalid_q || m_tready};

endmodule

// ----- rtl/vault_request_to_dram_commands.sv -----
// Top level of the vault request to DRAM command splitter.
`timescale 1ns / 1ps

// Takes one memory request word, maps its address to bank, column and row,
// and either emits one status word (invalid kind, or too little room in the
// bank queue for ceil(size/32)+1 commands) or an ACTIVATE followed by
// ceil(size/32) read or write commands, one result word per command, the
// final one marked with tlast. Sizes above the request limit are clamped.
// A small microcode sequencer walks through capture, check, activate and an
// access loop; each step that emits a word advances only when the output
// register is free. A 256-byte request yields an activate plus eight
// accesses. The output register lets the next request be captured while the
// final word of the previous one still waits for m_tready. keep_rows (reset
// 1) selects open-page mode; clear it to auto-precharge the last access of
// non-atomic requests. Write it only while the block is idle.
module vault_request_to_dram_commands #(
	parameter int MAX_BLOCK_BYTES   = 128,
	parameter int VAULT_COUNT       = 32,
	parameter int BANK_COUNT        = 16,
	parameter int COLUMN_COUNT      = 1024,
	parameter int ROW_COUNT         = 32768,
	parameter int MAX_REQUEST_BYTES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// atomic_op[5:0], address[39:6], data_size[48:40], tag[59:49],
	// bank_queue_free[66:60], zero fill up to 71
	input  logic [71:0] s_tdata,
	// func[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// cmd_tag[10:0], bank[14:11], column[24:15], row[39:25], cmd_size[48:40],
	// posted[49], atomic[50], last_access[51], op_code[57:52], zero fill
	output logic [63:0] m_tdata,
	// status[1:0], cmd_kind[4:2]
	output logic [4:0]  m_tuser,
	// last_of_run
	output logic        m_tlast,
	input  logic        cfg_we,
	// keep_rows
	input  logic        cfg_wdata
);
	import vrdc_pkg::*;

	ctl_t   ctl;
	flags_t flags;
	step_t  step;
	logic   go;

	// sequencer: one control word per step drives the datapath
	vrdc_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctl    (ctl),
		.go     (go),
		.step   (step)
	);

	// datapath: capture, map, count accesses, hold the outgoing word
	vrdc_dpath #(
		.MAX_BLOCK_BYTES   (MAX_BLOCK_BYTES),
		.VAULT_COUNT       (VAULT_COUNT),
		.BANK_COUNT        (BANK_COUNT),
		.COLUMN_COUNT      (COLUMN_COUNT),
		.ROW_COUNT         (ROW_COUNT),
		.MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.go        (go),
		.s_tvalid  (s_tvalid),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tready  (m_tready),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.flags     (flags),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// only the capture step takes a request word
	assign s_tready = ctl.accept;

	// a status word always closes its run
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser[1:0] != ST_OK)) |-> m_tlast)
		else $error("status word without tlast");

	// a captured request is checked in the very next cycle
	a_capture_check: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (step == STEP_CHECK))
		else $error("captured request not checked next");

	// an activate word on the output always carries last_access
	a_act_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser[1:0] == ST_OK) && (m_tuser[4:2] == CMD_ACT))
			|-> m_tdata[51])
		else $error("activate without last_access");

endmodule
